@@ sv/pnc_pkg.sv @@
// Shared types and constants for the periodic neighbor counter.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package pnc_pkg;

  // Default sizes for the top-level parameters.
  localparam int ATOM_DEPTH_DEF  = 4096;
  localparam int COORD_WIDTH_DEF = 24;

  // Fixed field widths.
  localparam int REG_W          = 23;
  localparam int COUNT_W        = 13;
  localparam int MODE_W         = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int OUT_TDATA_W    = 16;
  localparam int CMD_FIFO_DEPTH = 4;

  // Mode codes carried on the input tuser.
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BOX_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Z  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 2'd3;

  // Command kinds after decoding in the front end.
  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_QUERY,
    CMD_CLEAR
  } cmd_kind_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } back_state_t;

  // Configuration registers as seen by the back end.
  typedef struct packed {
    logic [REG_W-1:0] box_x;
    logic [REG_W-1:0] box_y;
    logic [REG_W-1:0] box_z;
    logic [REG_W-1:0] cutoff;
  } cfg_regs_t;

endpackage

@@ sv/pnc_front.sv @@
// Front end: accepts input words, decodes the mode into a command kind and
// holds one command for the queue. Depends on pnc_pkg.
`timescale 1ns / 1ps

module pnc_front #(
  parameter int COORD_WIDTH = pnc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pnc_pkg::MODE_W-1:0]    s_tuser,
  input  logic [3*COORD_WIDTH-1:0]      coords,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output pnc_pkg::cmd_kind_t            cmd_kind,
  output logic [3*COORD_WIDTH-1:0]      cmd_coords
);
  import pnc_pkg::*;

  cmd_kind_t kind_dec;

  // Map the mode code to a command; the unused code becomes a no-op command.
  always_comb begin
    case (s_tuser)
      MODE_LOAD:  kind_dec = CMD_LOAD;
      MODE_QUERY: kind_dec = CMD_QUERY;
      MODE_CLEAR: kind_dec = CMD_CLEAR;
      default:    kind_dec = CMD_NOP;
    endcase
  end

  // The holding register frees up whenever the queue takes its word.
  assign s_tready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_tready) begin
      cmd_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      cmd_kind   <= kind_dec;
      cmd_coords <= coords;
    end
  end

endmodule

@@ sv/pnc_cmd_fifo.sv @@
// Short command queue between the front end and the back end.
// Depends on pnc_pkg for its default depth.
`timescale 1ns / 1ps

module pnc_cmd_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = pnc_pkg::CMD_FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);
  import pnc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [NW-1:0]     fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != NW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + NW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ sv/pnc_back.sv @@
// Back end: atom table memory, load/clear handling, the query scan pipeline
// and the output result register. Depends on pnc_pkg.
`timescale 1ns / 1ps

module pnc_back #(
  parameter int ATOM_DEPTH  = pnc_pkg::ATOM_DEPTH_DEF,
  parameter int COORD_WIDTH = pnc_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pnc_pkg::cfg_regs_t              cfg,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  pnc_pkg::cmd_kind_t              cmd_kind,
  input  logic [3*COORD_WIDTH-1:0]        cmd_coords,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [pnc_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import pnc_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = (ATOM_DEPTH > 1) ? $clog2(ATOM_DEPTH) : 1;
  localparam int TW   = $clog2(ATOM_DEPTH + 1);
  localparam int MW   = CW + 1;
  localparam int EW   = (CW + 2 > REG_W + 1) ? CW + 2 : REG_W + 1;
  localparam int SQW  = 2 * MW;
  localparam int SUMW = SQW + 2;
  localparam int R2W  = 2 * REG_W;
  localparam int CMPW = (SUMW > R2W) ? SUMW : R2W;

  back_state_t state;
  back_state_t state_next;

  logic [3*CW-1:0]    atom_mem [ATOM_DEPTH];
  logic [TW-1:0]      atom_total;
  logic [TW-1:0]      total_inc;
  logic               room;
  logic [AW-1:0]      scan_idx;
  logic               scan_last;
  logic [3*CW-1:0]    center;
  logic [R2W-1:0]     r2;

  logic               rd_vld;
  logic [3*CW-1:0]    rd_data;
  logic               s2_vld;
  logic [MW-1:0]      s2_abs [3];
  logic               s3_vld;
  logic [MW-1:0]      s3_mag [3];
  logic               s4_vld;
  logic [SQW-1:0]     s4_sq [3];
  logic [CMPW-1:0]    dist_sum;
  logic               hit;
  logic [TW-1:0]      hit_count;
  logic               pipe_busy;

  logic               res_vld;
  logic [COUNT_W-1:0] res_count;
  logic               res_full;
  logic               res_free;
  logic               res_load;
  logic [COUNT_W-1:0] res_count_d;
  logic               res_full_d;
  logic               rd_en;
  logic               wr_en;
  logic               start_query;

  assign total_inc = atom_total + TW'(1);
  assign room      = (atom_total < TW'(ATOM_DEPTH));
  assign scan_last = ((TW'(scan_idx) + TW'(1)) == atom_total);
  assign res_free  = !res_vld || m_tready;
  assign pipe_busy = rd_vld || s2_vld || s3_vld || s4_vld;

  // Sequencer: next state and per-cycle controls.
  always_comb begin
    state_next  = state;
    cmd_ready   = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    start_query = 1'b0;
    res_load    = 1'b0;
    res_count_d = COUNT_W'(atom_total);
    res_full_d  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && res_free) begin
          cmd_ready = 1'b1;
          case (cmd_kind)
            CMD_LOAD: begin
              res_load    = 1'b1;
              wr_en       = room;
              res_full_d  = !room;
              res_count_d = room ? COUNT_W'(total_inc) : COUNT_W'(atom_total);
            end
            CMD_QUERY: begin
              start_query = 1'b1;
              if (atom_total == '0) begin
                res_load    = 1'b1;
                res_count_d = '0;
              end else begin
                state_next = ST_SCAN;
              end
            end
            CMD_CLEAR: begin
              res_load    = 1'b1;
              res_count_d = '0;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy && res_free) begin
          res_load    = 1'b1;
          res_count_d = COUNT_W'(hit_count);
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Atom count: a clear empties the table, a load with room appends.
  always_ff @(posedge clk) begin
    if (rst) begin
      atom_total <= '0;
    end else if (cmd_ready && cmd_kind == CMD_CLEAR) begin
      atom_total <= '0;
    end else if (wr_en) begin
      atom_total <= total_inc;
    end
  end

  // Atom table: one write port for loads, one registered read port for scans.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      atom_mem[atom_total[AW-1:0]] <= cmd_coords;
    end
    if (rd_en) begin
      rd_data <= atom_mem[scan_idx];
    end
  end

  // Scan address and query center.
  always_ff @(posedge clk) begin
    if (start_query) begin
      scan_idx <= '0;
      center   <= cmd_coords;
    end else if (rd_en) begin
      scan_idx <= scan_idx + AW'(1);
    end
  end

  // Squared cutoff, held ready for the compare stage.
  always_ff @(posedge clk) begin
    r2 <= R2W'(cfg.cutoff) * R2W'(cfg.cutoff);
  end

  // Valid bits of the scan pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      s2_vld <= rd_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
    end
  end

  // Per-axis datapath: absolute difference, one minimum-image fold, square.
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [CW:0] diff;
    logic [REG_W-1:0]   box;
    logic [EW-1:0]      d_e;
    logic [EW-1:0]      b_e;
    logic               fold;
    logic [EW-1:0]      fold_mag;

    assign diff = $signed({center[a*CW+CW-1], center[a*CW +: CW]})
                - $signed({rd_data[a*CW+CW-1], rd_data[a*CW +: CW]});
    assign box  = (a == 0) ? cfg.box_x : ((a == 1) ? cfg.box_y : cfg.box_z);
    assign d_e  = EW'(s2_abs[a]);
    assign b_e  = EW'(box);
    // Fold when twice the distance exceeds the box; only the magnitude is kept.
    assign fold     = ({d_e[EW-2:0], 1'b0} > b_e);
    assign fold_mag = (b_e >= d_e) ? (b_e - d_e) : (d_e - b_e);

    always_ff @(posedge clk) begin
      s2_abs[a] <= MW'(diff[CW] ? -diff : diff);
      s3_mag[a] <= fold ? MW'(fold_mag) : MW'(d_e);
      s4_sq[a]  <= SQW'(s3_mag[a]) * SQW'(s3_mag[a]);
    end
  end

  assign dist_sum = CMPW'(s4_sq[0]) + CMPW'(s4_sq[1]) + CMPW'(s4_sq[2]);
  assign hit      = (dist_sum < CMPW'(r2));

  // Neighbor tally for the running query.
  always_ff @(posedge clk) begin
    if (start_query) begin
      hit_count <= '0;
    end else if (s4_vld && hit) begin
      hit_count <= hit_count + TW'(1);
    end
  end

  // Output register: holds one result word until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (res_load) begin
      res_vld <= 1'b1;
    end else if (m_tready) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_count <= res_count_d;
      res_full  <= res_full_d;
    end
  end

  assign m_tvalid = res_vld;
  assign m_tdata  = {(OUT_TDATA_W - COUNT_W - 1)'(0), res_full, res_count};

endmodule

@@ sv/periodic_neighbor_counter.sv @@
// Periodic neighbor counter: keeps a table of up to ATOM_DEPTH atom positions and, for each
// query center, counts stored atoms whose minimum-image distance is strictly below the cutoff.
// Words enter through a holding register and a four-entry command queue, so input keeps
// flowing while a result waits on the output. Loads, clears and unused modes are answered in
// the idle state of the back end, so they go through at one per cycle when the output is
// drained. A query reads the table through the single read port of the atom memory, one atom
// per cycle, then drains the scan pipeline; an empty table is answered in idle. The atom table
// needs no clearing pass after reset. Depends on pnc_pkg, pnc_front, pnc_cmd_fifo, pnc_back.
`timescale 1ns / 1ps

module periodic_neighbor_counter #(
  parameter int ATOM_DEPTH  = pnc_pkg::ATOM_DEPTH_DEF,
  parameter int COORD_WIDTH = pnc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // coord_x, coord_y, coord_z, then zero padding
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,
  // mode
  input  logic [pnc_pkg::MODE_W-1:0]              s_tuser,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // neighbor_count, table_full, then zero padding
  output logic [pnc_pkg::OUT_TDATA_W-1:0]         m_tdata,
  input  logic                                    cfg_wr_en,
  input  logic [pnc_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [pnc_pkg::REG_W-1:0]               cfg_data
);
  import pnc_pkg::*;

  localparam int CMD_W = 3 * COORD_WIDTH + 2;

  cfg_regs_t                cfg;
  logic                     front_valid;
  logic                     front_ready;
  cmd_kind_t                front_kind;
  logic [3*COORD_WIDTH-1:0] front_coords;
  logic                     fifo_pop_valid;
  logic                     fifo_pop_ready;
  logic [CMD_W-1:0]         fifo_pop_data;
  cmd_kind_t                back_kind;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BOX_X:  cfg.box_x  <= cfg_data;
        REG_BOX_Y:  cfg.box_y  <= cfg_data;
        REG_BOX_Z:  cfg.box_z  <= cfg_data;
        REG_CUTOFF: cfg.cutoff <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pnc_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tuser    (s_tuser),
    .coords     (s_tdata[3*COORD_WIDTH-1:0]),
    .cmd_valid  (front_valid),
    .cmd_ready  (front_ready),
    .cmd_kind   (front_kind),
    .cmd_coords (front_coords)
  );

  pnc_cmd_fifo #(
    .DATA_W (CMD_W),
    .DEPTH  (CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  ({front_kind, front_coords}),
    .pop_valid  (fifo_pop_valid),
    .pop_ready  (fifo_pop_ready),
    .pop_data   (fifo_pop_data)
  );

  assign back_kind = cmd_kind_t'(fifo_pop_data[CMD_W-1 -: 2]);

  pnc_back #(
    .ATOM_DEPTH  (ATOM_DEPTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd_valid  (fifo_pop_valid),
    .cmd_ready  (fifo_pop_ready),
    .cmd_kind   (back_kind),
    .cmd_coords (fifo_pop_data[3*COORD_WIDTH-1:0]),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  // A reported full table always carries a count equal to the table depth.
  a_full_count : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[COUNT_W]) |-> (m_tdata[COUNT_W-1:0] == COUNT_W'(ATOM_DEPTH)))
    else $error("table_full reported with a count other than the table depth");

  // The back end takes no command while a result sits stalled on the output.
  a_no_pop_on_stall : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(fifo_pop_valid && fifo_pop_ready))
    else $error("command taken while the output word was stalled");

  // A word the front end could not hand over is still offered next cycle.
  a_front_holds : assert property (@(posedge clk) disable iff (rst)
    (front_valid && !front_ready) |=> front_valid)
    else $error("front end dropped a command before the queue took it");

endmodule
